### rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg: shared types and codes for the setpoint stepper
// Item structs, configuration and state bundles, multiplier and register codes.
// ----------------------------------------------------------------------------
package sps_pkg;

    // input item codes
    localparam logic OP_HOLD    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;
    localparam logic DIR_UP     = 1'b0;
    localparam logic DIR_DOWN   = 1'b1;

    // result kinds
    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    // multiplier codes
    localparam logic [2:0] MULT_ZERO        = 3'd0;
    localparam logic [2:0] MULT_ONE         = 3'd1;
    localparam logic [2:0] MULT_FIVE        = 3'd2;
    localparam logic [2:0] MULT_TEN         = 3'd3;
    localparam logic [2:0] MULT_TWENTY_FIVE = 3'd4;

    // tick count thresholds
    localparam logic [4:0] COUNT_FIVE_AT  = 5'd10;
    localparam logic [4:0] COUNT_TEN_AT   = 5'd20;
    localparam logic [4:0] COUNT_MAX      = 5'd30;

    // register indexes
    localparam logic [1:0] REG_STEP_SIZE    = 2'd0;
    localparam logic [1:0] REG_MIN_SETPOINT = 2'd1;
    localparam logic [1:0] REG_MAX_SETPOINT = 2'd2;

    // register reset values
    localparam logic [14:0]        STEP_SIZE_RST    = 15'd16;
    localparam logic signed [15:0] MIN_SETPOINT_RST = 16'sd0;
    localparam logic signed [15:0] MAX_SETPOINT_RST = 16'sd1600;

    typedef struct packed {
        logic op;
        logic direction;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic               changed;
        logic signed [15:0] previous_setpoint;
        logic signed [15:0] new_setpoint;
        logic               drive_off;
        logic [15:0]        store_word;
    } t_out_item;

    typedef struct packed {
        logic [14:0]        step_size;
        logic signed [15:0] min_setpoint;
        logic signed [15:0] max_setpoint;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] setpoint;
        logic [4:0]         tick_count;
        logic [2:0]         mult_code;
        logic               holding;
        logic               hold_direction;
    } t_state;

endpackage

### rtl/accelerating_setpoint_stepper.sv
// ----------------------------------------------------------------------------
// accelerating_setpoint_stepper: held-button setpoint stepper
// Accelerating up/down stepping of a Q12.4 setpoint with store report on release.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_item) takes one item per
//   paced button tick or release. Output channel (o_out_valid, i_out_stall,
//   o_out_item) gives exactly one result item for each input item.
//   The APB port holds step_size (0x0), min_setpoint (0x4), max_setpoint (0x8);
//   write it only while no item is in flight.
// Timing:
//   An item is registered at the input, then worked through the
//   step datapath into the result register; throughput one item per cycle
//   unless stalled. The setpoint/count/multiplier state updates in the same
//   cycle the result register loads, so the next item sees it directly.
// Stall:
//   While the receiver stalls, the result register holds and one more item
//   can wait in the input register; only then is o_in_stall raised.
// Reset:
//   Synchronous active-low reset empties both registers, puts the setpoint to
//   zero, multiplier to one, ends any hold and loads the register defaults.
// ----------------------------------------------------------------------------
module accelerating_setpoint_stepper
    import sps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_result;
    logic      in_accept;
    logic      move;
    logic      cfg_write;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size    <= STEP_SIZE_RST;
            r_cfg.min_setpoint <= MIN_SETPOINT_RST;
            r_cfg.max_setpoint <= MAX_SETPOINT_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_STEP_SIZE:    r_cfg.step_size    <= pwdata[14:0];
                REG_MIN_SETPOINT: r_cfg.min_setpoint <= pwdata[15:0];
                REG_MAX_SETPOINT: r_cfg.max_setpoint <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            REG_STEP_SIZE:    prdata = {17'd0, r_cfg.step_size};
            REG_MIN_SETPOINT: prdata = {16'd0, r_cfg.min_setpoint};
            REG_MAX_SETPOINT: prdata = {16'd0, r_cfg.max_setpoint};
            default:          prdata = 32'd0;
        endcase
    end

    // handshake: input register feeds the result register
    assign move       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !move);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // step datapath
    sps_step u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_result (n_result),
        .o_state  (n_state)
    );

    // stepper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.setpoint       <= 16'sd0;
            r_state.tick_count     <= 5'd0;
            r_state.mult_code      <= MULT_ONE;
            r_state.holding        <= 1'b0;
            r_state.hold_direction <= DIR_UP;
        end else if (move) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_item <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // checks
    a_move_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (o_out_valid && o_out_item.previous_setpoint == $past(r_state.setpoint)))
        else $error("result register not loaded from current state");

    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == KIND_STORE) |->
        (!o_out_item.changed && !o_out_item.drive_off &&
         o_out_item.new_setpoint == o_out_item.previous_setpoint))
        else $error("store report carries a step");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (r_state.tick_count <= COUNT_MAX && r_state.mult_code <= MULT_TWENTY_FIVE))
        else $error("tick count or multiplier code out of range");

endmodule

### rtl/sps_step.sv
// ----------------------------------------------------------------------------
// sps_step: one-item step datapath
// Computes the result item and the next stepper state for one input item.
// ----------------------------------------------------------------------------
module sps_step
    import sps_pkg::*;
(
    input  t_in_item  i_item,
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    output t_out_item o_result,
    output t_state    o_state
);

    always_comb begin
        logic               start_hold;
        logic               down;
        logic               pass;
        logic [2:0]         code0;
        logic [4:0]         cnt0;
        logic [2:0]         code1;
        logic [2:0]         code2;
        logic               reduced;
        logic [4:0]         cnt2;
        logic [4:0]         cnt3;
        logic [2:0]         code3;
        logic signed [21:0] sp22;
        logic signed [21:0] d22;
        logic signed [21:0] min22;
        logic signed [21:0] max22;
        logic signed [21:0] c1;
        logic signed [21:0] c5;
        logic signed [21:0] c10;
        logic signed [21:0] c25;
        logic signed [21:0] c_sel;
        logic               b1;
        logic               b5;
        logic               b10;
        logic               b25;
        logic [16:0]        sp17;
        logic [16:0]        mag;
        logic [16:0]        rnd;
        logic [15:0]        r16;

        // hold start and stop test
        down       = (i_item.direction == DIR_DOWN);
        start_hold = !i_state.holding || (i_state.hold_direction != i_item.direction);
        code0      = start_hold ? MULT_ONE : i_state.mult_code;
        cnt0       = start_hold ? 5'd0 : i_state.tick_count;
        pass       = down ? (i_state.setpoint >= i_cfg.min_setpoint)
                          : (i_state.setpoint <= i_cfg.max_setpoint);
        code1      = (code0 > MULT_TWENTY_FIVE) ? MULT_ONE : code0;

        // candidate setpoints for each multiplier
        sp22  = 22'(i_state.setpoint);
        min22 = 22'(i_cfg.min_setpoint);
        max22 = 22'(i_cfg.max_setpoint);
        d22   = down ? -$signed({7'd0, i_cfg.step_size}) : $signed({7'd0, i_cfg.step_size});
        c1    = sp22 + d22;
        c5    = sp22 + (d22 <<< 2) + d22;
        c10   = sp22 + (d22 <<< 3) + (d22 <<< 1);
        c25   = sp22 + (d22 <<< 4) + (d22 <<< 3) + d22;
        b1    = down ? (c1  < min22) : (c1  > max22);
        b5    = down ? (c5  < min22) : (c5  > max22);
        b10   = down ? (c10 < min22) : (c10 > max22);
        b25   = down ? (c25 < min22) : (c25 > max22);

        // overshoot reduction: walk down from the current multiplier
        code2   = code1;
        reduced = 1'b0;
        unique case (code1)
            MULT_TWENTY_FIVE: begin
                priority if (!b25) code2 = MULT_TWENTY_FIVE;
                else if (!b10)     code2 = MULT_TEN;
                else if (!b5)      code2 = MULT_FIVE;
                else if (!b1)      code2 = MULT_ONE;
                else               code2 = MULT_ZERO;
                reduced = b25;
            end
            MULT_TEN: begin
                priority if (!b10) code2 = MULT_TEN;
                else if (!b5)      code2 = MULT_FIVE;
                else if (!b1)      code2 = MULT_ONE;
                else               code2 = MULT_ZERO;
                reduced = b10;
            end
            MULT_FIVE: begin
                priority if (!b5) code2 = MULT_FIVE;
                else if (!b1)     code2 = MULT_ONE;
                else              code2 = MULT_ZERO;
                reduced = b5;
            end
            MULT_ONE: begin
                code2   = b1 ? MULT_ZERO : MULT_ONE;
                reduced = b1;
            end
            default: begin
                code2   = MULT_ZERO;
                reduced = 1'b0;
            end
        endcase

        // sum for the chosen multiplier
        unique case (code2)
            MULT_TWENTY_FIVE: c_sel = c25;
            MULT_TEN:         c_sel = c10;
            MULT_FIVE:        c_sel = c5;
            MULT_ONE:         c_sel = c1;
            default:          c_sel = sp22;
        endcase

        // count update and acceleration
        cnt2 = reduced ? ((code2 == MULT_FIVE) ? COUNT_FIVE_AT : 5'd0) : cnt0;
        cnt3 = (cnt2 < COUNT_MAX) ? cnt2 + 5'd1 : cnt2;
        priority if (cnt3 < COUNT_FIVE_AT) code3 = code2;
        else if (cnt3 < COUNT_TEN_AT)      code3 = MULT_FIVE;
        else if (cnt3 < COUNT_MAX)         code3 = MULT_TEN;
        else                               code3 = MULT_TWENTY_FIVE;

        // store word: rounded half away from zero, times ten
        sp17 = 17'(i_state.setpoint);
        mag  = sp17[16] ? (17'd0 - sp17) : sp17;
        rnd  = (mag + 17'd8) >> 4;
        r16  = sp17[16] ? (16'd0 - rnd[15:0]) : rnd[15:0];

        o_state  = i_state;
        o_result.kind              = KIND_STEP;
        o_result.changed           = 1'b0;
        o_result.previous_setpoint = i_state.setpoint;
        o_result.new_setpoint      = i_state.setpoint;
        o_result.drive_off         = 1'b0;
        o_result.store_word        = 16'd0;

        if (i_item.op == OP_RELEASE) begin
            o_result.kind       = KIND_STORE;
            o_result.store_word = (r16 << 3) + (r16 << 1);
            o_state.holding     = 1'b0;
        end else begin
            o_result.drive_off     = start_hold;
            o_state.holding        = 1'b1;
            o_state.hold_direction = i_item.direction;
            o_state.mult_code      = code0;
            o_state.tick_count     = cnt0;
            if (pass) begin
                o_state.mult_code  = code3;
                o_state.tick_count = cnt3;
                o_state.setpoint   = c_sel[15:0];
                o_result.changed   = (code2 != MULT_ZERO);
            end
            o_result.new_setpoint = o_state.setpoint;
        end
    end

endmodule
